// ----- rtl/core/mwma_pkg.sv -----
package mwma_pkg;

   // window geometry
   localparam int WIN_COUNT = 6;
   localparam int unsigned WIN_LEN [WIN_COUNT] = '{15, 30, 60, 180, 300, 600};

   // datapath widths
   localparam int SAMPLE_W  = 16;
   localparam int POS_W     = 10;
   localparam int CNT_W     = 11;
   localparam int TOTAL_W   = 26;
   localparam int REM_W     = 11;
   localparam int DIV_STEPS = TOTAL_W;
   localparam int STEP_W    = 5;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   // input item
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                reading_failed;
   } req_type;

   // result item
   typedef struct packed {
      logic [SAMPLE_W-1:0] current_value;
      logic [SAMPLE_W-1:0] mean_short;
      logic [SAMPLE_W-1:0] mean_second;
      logic [SAMPLE_W-1:0] mean_third;
      logic [SAMPLE_W-1:0] mean_fourth;
      logic [SAMPLE_W-1:0] mean_fifth;
      logic [SAMPLE_W-1:0] mean_long;
   } rsp_type;

   // divider lane control
   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

// ----- rtl/core/mwma_ram.sv -----
module mwma_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/mwma_ring.sv -----
module mwma_ring
   import mwma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [CNT_W-1:0]    win_len,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] old_data,
   output logic [POS_W-1:0]    pos,
   output logic [TOTAL_W-1:0]  total,
   output logic [CNT_W-1:0]    count
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               filled_ff, filled_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   pos_inc;
   logic [TOTAL_W-1:0] drop;

   // drop the oldest entry once wrapped, add the new sample
   always_comb begin
      pos_in    = pos_ff;
      filled_in = filled_ff;
      total_in  = total_ff;
      pos_inc   = {1'b0, pos_ff} + CNT_W'(1);
      drop      = filled_ff ? TOTAL_W'(old_data) : '0;
      if (push) begin
         total_in = total_ff - drop + TOTAL_W'(sample);
         if (pos_inc >= win_len) begin
            pos_in    = '0;
            filled_in = 1'b1;
         end else begin
            pos_in = pos_inc[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filled_ff <= 1'b0;
         total_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         filled_ff <= filled_in;
         total_ff  <= total_in;
      end
   end

   assign pos   = pos_ff;
   assign total = total_ff;
   assign count = filled_ff ? win_len : {1'b0, pos_ff};

endmodule

// ----- rtl/core/mwma_div.sv -----
module mwma_div
   import mwma_pkg::*;
(
   input  logic                clock,
   input  div_ctl_type         ctl,
   input  logic [TOTAL_W-1:0]  dividend,
   input  logic [CNT_W-1:0]    divisor,
   output logic [SAMPLE_W-1:0] quotient
);

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]   shifted;
   logic               fits;

   // restoring division, one quotient bit per cycle while step is set
   always_comb begin
      shifted = {rem_ff[REM_W-2:0], quo_ff[TOTAL_W-1]};
      fits    = (shifted >= divisor);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctl.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (ctl.step) begin
         rem_in = fits ? (shifted - divisor) : shifted;
         quo_in = {quo_ff[TOTAL_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // empty window reads as zero
   assign quotient = (divisor == '0) ? '0 : quo_ff[SAMPLE_W-1:0];

endmodule

// ----- rtl/core/multi_window_moving_average.sv -----
// Moving averages of a Q8.8 utilization sample over six windows of 15, 30, 60,
// 180, 300 and 600 samples. Each input transfer gives exactly one result
// transfer carrying the last good sample and the six truncated means (0 for a
// window that holds no sample yet); a transfer flagged as a failed reading
// leaves all history untouched. Each mean comes from one of the 26-step
// bit-serial dividers, one per window, that run side by side after the history
// memories are read and updated; a failed reading skips the read and update.
// The next item is taken once the result sits in the output register, so a
// held result stalls at most one further item.
module multi_window_moving_average
   import mwma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   req_type             req_ff;
   logic [SAMPLE_W-1:0] last_good_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   logic        req_xfer;
   logic        rsp_load;
   logic        push;
   logic        last_step;
   div_ctl_type div_ctl;

   logic [POS_W-1:0]    pos   [WIN_COUNT];
   logic [TOTAL_W-1:0]  total [WIN_COUNT];
   logic [CNT_W-1:0]    count [WIN_COUNT];
   logic [SAMPLE_W-1:0] old   [WIN_COUNT];
   logic [SAMPLE_W-1:0] mean  [WIN_COUNT];

   assign req_xfer  = req_valid && !req_stall;
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_data.reading_failed ? ST_LOAD : ST_READ;
            end
         end
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (last_step) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall    = 1'b1;
      push         = 1'b0;
      div_ctl      = '0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_READ:   ;
         ST_UPDATE: push = 1'b1;
         ST_LOAD:   div_ctl.load = 1'b1;
         ST_DIVIDE: div_ctl.step = 1'b1;
         ST_HOLD:   rsp_load = !rsp_valid_ff || !rsp_stall;
         default:   ;
      endcase
   end

   // step counter and output register valid
   always_comb begin
      step_in = (state_ff == ST_DIVIDE) ? (step_ff + STEP_W'(1)) : '0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         last_good_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer && !req_data.reading_failed) begin
            last_good_ff <= req_data.sample;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff.current_value <= last_good_ff;
         rsp_ff.mean_short    <= mean[0];
         rsp_ff.mean_second   <= mean[1];
         rsp_ff.mean_third    <= mean[2];
         rsp_ff.mean_fourth   <= mean[3];
         rsp_ff.mean_fifth    <= mean[4];
         rsp_ff.mean_long     <= mean[5];
      end
   end

   // one history memory, ring tracker and divider lane per window
   for (genvar g = 0; g < WIN_COUNT; g++) begin : g_win
      localparam int DEPTH  = int'(WIN_LEN[g]);
      localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

      mwma_ram #(
         .DEPTH  (DEPTH),
         .WIDTH  (SAMPLE_W),
         .ADDR_W (ADDR_W)
      ) u_ram (
         .clock   (clock),
         .wr_en   (push),
         .wr_addr (pos[g][ADDR_W-1:0]),
         .wr_data (req_ff.sample),
         .rd_addr (pos[g][ADDR_W-1:0]),
         .rd_data (old[g])
      );

      mwma_ring u_ring (
         .clock    (clock),
         .reset    (reset),
         .push     (push),
         .win_len  (CNT_W'(WIN_LEN[g])),
         .sample   (req_ff.sample),
         .old_data (old[g]),
         .pos      (pos[g]),
         .total    (total[g]),
         .count    (count[g])
      );

      mwma_div u_div (
         .clock    (clock),
         .ctl      (div_ctl),
         .dividend (total[g]),
         .divisor  (count[g]),
         .quotient (mean[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_div_to_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && last_step) |=> (state_ff == ST_HOLD))
      else $error("divider did not finish after the last step");

   a_hold_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not presented after hold");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE && req_stall))
      else $error("input taken while an item was in flight");

   a_push_after_read: assert property (@(posedge clock) disable iff (reset)
      push |-> ($past(state_ff) == ST_READ))
      else $error("history written without a prior read");
`endif

endmodule
